/* hw/rtl/stt_pkg.sv */
// types and constants shared by the software timer table
// no dependencies
package stt_pkg;

  localparam int unsigned MaxResults = 16;
  localparam int unsigned CountW     = 5;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    KIND_CREATED = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_DELETED = 3'd2,
    KIND_EXPIRY  = 3'd3,
    KIND_NO_EXP  = 3'd4
  } kind_e;

  typedef struct packed {
    req_type_e   req_type;
    logic [3:0]  slot_id;
    logic [31:0] period_ticks;
    logic        one_shot;
    logic [7:0]  handler_tag;
    logic [31:0] cookie;
  } req_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  slot_out;
    logic [7:0]  tag_out;
    logic [31:0] cookie_out;
    logic        machine_mode;
    logic        last;
  } rsp_t;

  // contents of one timer slot
  typedef struct packed {
    logic        live;
    logic        one_shot;
    logic [63:0] deadline;
    logic [31:0] period;
    logic [7:0]  tag;
    logic [31:0] cookie;
  } slot_t;

endpackage

/* hw/rtl/stt_cell.sv */
// one timer slot cell of the rotating ring
// depends on stt_pkg
module stt_cell import stt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  slot_t slot_i,
  output slot_t slot_o
);

  logic  live_q;
  slot_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
    end else if (shift_i) begin
      live_q <= slot_i.live;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= slot_i;
    end
  end

  always_comb begin
    slot_o      = data_q;
    slot_o.live = live_q;
  end

endmodule

/* hw/rtl/software_timer_table.sv */
// software timer table: create, delete and tick over a rotating ring of slot cells
// create, delete and tick each rotate the ring once through all NUM_SLOTS slots, then
// present the final item; a new request is taken only in idle, once that item is loaded
// the ring moves one slot past the head compare unit per cycle, stalling on back-pressure
// reset clears the tick counter and every slot's live flag; no clearing pass
module software_timer_table import stt_pkg::*; #(
  parameter int unsigned NUM_SLOTS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t rsp_o
);

  localparam int unsigned IdxW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned StepW = IdxW + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  req_t   req_q;
  logic [63:0] tick_q;
  logic [StepW-1:0] step_q;
  logic [CountW-1:0] nexp_q;
  logic found_q;
  logic [IdxW-1:0] fslot_q;
  logic pend_v_q;
  rsp_t pend_q;
  logic out_v_q, out_v_d;
  rsp_t out_q;

  // ring of cells; cell 0 is the head, the modified head re-enters at the tail
  slot_t ring_q [NUM_SLOTS];
  slot_t head_new;
  logic  shift;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    slot_t cell_in;
    if (g == NUM_SLOTS - 1) begin : g_tail
      assign cell_in = head_new;
    end else begin : g_mid
      assign cell_in = ring_q[g+1];
    end
    stt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .slot_i (cell_in),
      .slot_o (ring_q[g])
    );
  end

  slot_t head;
  logic [IdxW-1:0] idx;
  logic due, out_busy, stall, push_pend, out_load;
  rsp_t exp_rsp;

  assign head     = ring_q[0];
  assign idx      = step_q[IdxW-1:0];
  assign out_busy = out_v_q && !out_ready_i;

  // head compare unit: one slot per cycle, unless stalled by back-pressure
  always_comb begin
    head_new  = head;
    due       = 1'b0;
    exp_rsp   = '0;
    case (req_q.req_type)
      REQ_CREATE: begin
        if (!found_q && !head.live) begin
          head_new.live     = 1'b1;
          head_new.one_shot = req_q.one_shot;
          head_new.period   = req_q.period_ticks;
          head_new.tag      = req_q.handler_tag;
          head_new.cookie   = req_q.cookie;
          head_new.deadline = tick_q + 64'(req_q.period_ticks);
        end
      end
      REQ_DELETE: begin
        if (9'(req_q.slot_id) == 9'(step_q)) begin
          head_new.live = 1'b0;
        end
      end
      REQ_TICK: begin
        due = head.live && (head.deadline <= tick_q) && (nexp_q < CountW'(MaxResults));
        if (due) begin
          head_new.live     = !head.one_shot;
          head_new.deadline = tick_q + 64'(head.period);
        end
      end
      default: ;
    endcase
    exp_rsp.kind         = KIND_EXPIRY;
    exp_rsp.slot_out     = 4'(idx);
    exp_rsp.tag_out      = head.tag;
    exp_rsp.cookie_out   = head.cookie;
    exp_rsp.machine_mode = (head.tag == 8'd0);
    exp_rsp.last         = 1'b0;
  end

  // an earlier expiry moves to the output when a later one shows up
  assign push_pend = (state_q == ST_SCAN) && due && pend_v_q;
  assign stall     = push_pend && out_busy;
  assign shift     = (state_q == ST_SCAN) && !stall;

  // output register loads a new item, else drops the one taken
  assign out_load = (push_pend && shift) || (state_q == ST_DONE && !out_busy);
  assign out_v_d  = out_load ? 1'b1 : (out_v_q && !out_ready_i);

  // final item of a request
  rsp_t fin_rsp;
  always_comb begin
    fin_rsp      = '0;
    fin_rsp.last = 1'b1;
    case (req_q.req_type)
      REQ_CREATE: begin
        fin_rsp.kind     = found_q ? KIND_CREATED : KIND_FULL;
        fin_rsp.slot_out = found_q ? 4'(fslot_q) : 4'd0;
      end
      REQ_DELETE: begin
        fin_rsp.kind     = KIND_DELETED;
        fin_rsp.slot_out = req_q.slot_id;
      end
      default: begin
        if (pend_v_q) begin
          fin_rsp      = pend_q;
          fin_rsp.last = 1'b1;
        end else begin
          fin_rsp.kind = KIND_NO_EXP;
        end
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && req_i.req_type != REQ_NONE) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (shift && step_q == StepW'(NUM_SLOTS - 1)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tick_q   <= '0;
      step_q   <= '0;
      nexp_q   <= '0;
      found_q  <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
      case (state_q)
        ST_IDLE: begin
          step_q   <= '0;
          nexp_q   <= '0;
          found_q  <= 1'b0;
          pend_v_q <= 1'b0;
          if (in_valid_i && req_i.req_type == REQ_TICK) tick_q <= tick_q + 64'd1;
        end
        ST_SCAN: begin
          if (shift) begin
            step_q <= step_q + StepW'(1);
            if (req_q.req_type == REQ_CREATE && !found_q && !head.live) begin
              found_q <= 1'b1;
            end
            if (due) begin
              pend_v_q <= 1'b1;
              nexp_q   <= nexp_q + CountW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) req_q <= req_i;
    if (state_q == ST_SCAN && shift) begin
      if (req_q.req_type == REQ_CREATE && !found_q && !head.live) fslot_q <= idx;
      if (due) pend_q <= exp_rsp;
      if (push_pend) out_q <= pend_q;
    end
    if (state_q == ST_DONE && !out_busy) out_q <= fin_rsp;
  end

  assign out_valid_o = out_v_q;
  assign rsp_o       = out_q;

endmodule
